// File: design/cec_pkg.sv
// Shared types and constants for the 3x3 edge-clamped convolution unit.
// No dependencies; every other design file imports this package.
package cec_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int COEF_BITS_DEF  = 7;
    localparam int KERNEL_BITS    = 63;
    localparam int WIDTH_REG_BITS = 12;
    localparam int HEIGHT_BITS    = 16;
    localparam int ROW_BITS       = HEIGHT_BITS + 1;  // row runs to height+1 while flushing
    localparam int CFG_IDX_BITS   = 2;
    localparam int OUT_FIFO_DEPTH = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd2;

    typedef logic [23:0] t_rgb;        // {red, green, blue}
    typedef t_rgb [2:0]  t_col;        // one window column, index 0 = top row

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       drain;
    } t_pix;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_image;
    } t_res;

    // control handed from the position tracker to the window stage
    typedef struct packed {
        logic valid;
        logic row_is1;
        logic flushing;
        logic emit;
        logic emit_a;     // result for the previous row's last pixel
        logic sel_left;   // left column taken from the newest old column
        logic eoi;
        t_rgb pix;
    } t_s1_ctl;

    // 3x3 neighborhood, [row][col]
    typedef struct packed {
        logic             valid;
        logic             eoi;
        t_rgb [2:0][2:0]  nbr;
    } t_nbr;

endpackage

// File: design/cec_ifs.sv
// Valid/ready channel interfaces: pixel requests, results and config writes.
// Depends on cec_pkg.
interface cec_pix_if import cec_pkg::*; ();
    logic valid;
    logic ready;
    t_pix data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cec_res_if import cec_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cec_cfg_if import cec_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [KERNEL_BITS-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/conv3x3_edge_clamp_unit.sv
// Path: each accepted request passes the tracker, window, product and FIFO registers; the request
//   completing a neighborhood trails the matching pixel by width+1 requests (hence width+1 drains).
// Throughput: one request per cycle when ready; each line store does one read and one write per cycle.
// Pixel ready drops for one cycle after an image_width or image_height write, and while
//   OUT_FIFO_DEPTH results are owed to a stalled output.
// Reset (sync, active low): kernel 0, 1x1 image, position and window cleared; line stores keep data.
module conv3x3_edge_clamp_unit import cec_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cec_pix_if.sink   i_pix,
    cec_res_if.source o_res,
    cec_cfg_if.sink   i_cfg
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WEFF_BITS = $clog2(MAX_WIDTH + 1);
    localparam int TOT_BITS  = WEFF_BITS + HEIGHT_BITS;
    localparam int PTR_BITS  = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_BITS  = $clog2(OUT_FIFO_DEPTH + 1);

    // ---------------- configuration registers ----------------
    logic [KERNEL_BITS-1:0]    r_kernel;
    logic [WIDTH_REG_BITS-1:0] r_img_w;
    logic [HEIGHT_BITS-1:0]    r_img_h;
    logic [TOT_BITS-1:0]       r_total_m1;   // pixels per image minus one
    logic                      r_cfg_pend;   // geometry just written, product not settled yet
    logic                      cfg_acc, geom_wr;

    logic [WEFF_BITS-1:0]      weff;
    logic [HEIGHT_BITS-1:0]    heff;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign geom_wr     = cfg_acc && ((i_cfg.index == REG_WIDTH) || (i_cfg.index == REG_HEIGHT));

    // zero reads as one, widths past the line store depth clip to it
    always_comb begin
        if (r_img_w == '0) begin
            weff = WEFF_BITS'(1);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            weff = WEFF_BITS'(MAX_WIDTH);
        end else begin
            weff = WEFF_BITS'(r_img_w);
        end
        heff = (r_img_h == '0) ? HEIGHT_BITS'(1) : r_img_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel   <= '0;
            r_img_w    <= WIDTH_REG_BITS'(1);
            r_img_h    <= HEIGHT_BITS'(1);
            r_total_m1 <= '0;
            r_cfg_pend <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    REG_KERNEL: r_kernel <= i_cfg.data;
                    REG_WIDTH:  r_img_w  <= i_cfg.data[WIDTH_REG_BITS-1:0];
                    REG_HEIGHT: r_img_h  <= i_cfg.data[HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            r_cfg_pend <= geom_wr;
            if (r_cfg_pend) begin
                r_total_m1 <= TOT_BITS'(weff) * TOT_BITS'(heff) - TOT_BITS'(1);
            end
        end
    end

    // ---------------- input handshake ----------------
    // r_pending counts results decided at the input but not yet taken at the output;
    // bounding it by the FIFO depth means the pipeline itself never stalls.
    logic [CNT_BITS-1:0] r_pending;
    logic                pix_acc, result_taken, res_pop;

    assign i_pix.ready = !r_cfg_pend && (r_pending < CNT_BITS'(OUT_FIFO_DEPTH));
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // ---------------- position tracking / line store read ----------------
    logic                rd_en;
    logic [COL_BITS-1:0] rd_col;
    t_s1_ctl             s1;
    logic [COL_BITS-1:0] s1_col;

    cec_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (pix_acc),
        .i_pix          (i_pix.data),
        .i_restart      (geom_wr),
        .i_weff         (weff),
        .i_heff         (heff),
        .i_total_m1     (r_total_m1),
        .o_rd_en        (rd_en),
        .o_rd_col       (rd_col),
        .o_result_taken (result_taken),
        .o_s1           (s1),
        .o_s1_col       (s1_col)
    );

    // ---------------- line stores (two rows back) ----------------
    t_rgb                upper_rd, lower_rd, wr_upper, wr_lower;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_col;

    cec_line_mem #(.DEPTH(MAX_WIDTH)) u_mem_upper (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_col),
        .o_rd_data (upper_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_col),
        .i_wr_data (wr_upper)
    );

    cec_line_mem #(.DEPTH(MAX_WIDTH)) u_mem_lower (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_col),
        .o_rd_data (lower_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_col),
        .i_wr_data (wr_lower)
    );

    // ---------------- window and neighborhood select ----------------
    t_nbr nbr;

    cec_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1       (s1),
        .i_s1_col   (s1_col),
        .i_upper    (upper_rd),
        .i_lower    (lower_rd),
        .o_wr_en    (wr_en),
        .o_wr_col   (wr_col),
        .o_wr_upper (wr_upper),
        .o_wr_lower (wr_lower),
        .o_nbr      (nbr)
    );

    // ---------------- kernel products, sum, clamp ----------------
    logic mac_valid;
    t_res mac_res;

    cec_mac #(.COEF_BITS(COEF_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kernel (r_kernel),
        .i_nbr    (nbr),
        .o_valid  (mac_valid),
        .o_res    (mac_res)
    );

    // ---------------- output FIFO ----------------
    t_res                r_fifo [OUT_FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, r_rptr;
    logic [CNT_BITS-1:0] r_cnt;

    assign o_res.valid = r_cnt != '0;
    assign o_res.data  = r_fifo[r_rptr];
    assign res_pop     = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (mac_valid) begin
            r_fifo[r_wptr] <= mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_cnt     <= '0;
            r_pending <= '0;
        end else begin
            if (mac_valid) begin
                r_wptr <= r_wptr + PTR_BITS'(1);
            end
            if (res_pop) begin
                r_rptr <= r_rptr + PTR_BITS'(1);
            end
            case ({mac_valid, res_pop})
                2'b10:   r_cnt <= r_cnt + CNT_BITS'(1);
                2'b01:   r_cnt <= r_cnt - CNT_BITS'(1);
                default: r_cnt <= r_cnt;
            endcase
            case ({result_taken, res_pop})
                2'b10:   r_pending <= r_pending + CNT_BITS'(1);
                2'b01:   r_pending <= r_pending - CNT_BITS'(1);
                default: r_pending <= r_pending;
            endcase
        end
    end

endmodule

// File: design/cec_line_mem.sv
// One line store: simple dual-port RAM, registered read, write-first bypass.
// Depends on cec_pkg.
module cec_line_mem import cec_pkg::*; #(
    parameter int  DEPTH = MAX_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_rgb          o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_rgb          i_wr_data
);

    t_rgb r_mem [DEPTH];
    t_rgb r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // same-address write in the same cycle wins (one-pixel-wide rows)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/cec_ctrl.sv
// Stream position tracker: row/column/result count, result decision, line store read.
// Depends on cec_pkg.
module cec_ctrl import cec_pkg::*; #(
    parameter int  MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int WEFF_BITS = $clog2(MAX_WIDTH + 1),
    localparam int TOT_BITS  = WEFF_BITS + HEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_pix                   i_pix,
    input  logic                   i_restart,
    input  logic [WEFF_BITS-1:0]   i_weff,
    input  logic [HEIGHT_BITS-1:0] i_heff,
    input  logic [TOT_BITS-1:0]    i_total_m1,
    output logic                   o_rd_en,
    output logic [COL_BITS-1:0]    o_rd_col,
    output logic                   o_result_taken,
    output t_s1_ctl                o_s1,
    output logic [COL_BITS-1:0]    o_s1_col
);

    logic [COL_BITS-1:0]  r_col, n_col;
    logic [ROW_BITS-1:0]  r_row, n_row;
    logic [TOT_BITS-1:0]  r_ocnt, n_ocnt;
    t_s1_ctl              r_s1, n_s1;
    logic [COL_BITS-1:0]  r_s1_col;

    logic [ROW_BITS-1:0]  heff_x;
    logic [WEFF_BITS-1:0] col_inc;
    logic                 flushing, advance, emit_a, emit_b, emit, last;

    always_comb begin
        heff_x   = ROW_BITS'(i_heff);
        flushing = r_row >= heff_x;
        // a drain before all pixels are in is dropped
        advance  = i_accept && (flushing || !i_pix.drain);
        emit_a   = (r_col == '0) && (r_row >= ROW_BITS'(2))
                   && ((r_row - ROW_BITS'(2)) < heff_x);
        emit_b   = (r_col != '0) && (r_row != '0) && (r_row <= heff_x);
        emit     = emit_a || emit_b;
        last     = emit && (r_ocnt >= i_total_m1);
        col_inc  = WEFF_BITS'(r_col) + WEFF_BITS'(1);

        n_col  = r_col;
        n_row  = r_row;
        n_ocnt = r_ocnt;
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_ocnt = '0;
        end else if (advance) begin
            if (last) begin
                n_col  = '0;
                n_row  = '0;
                n_ocnt = '0;
            end else begin
                if (col_inc >= i_weff) begin
                    n_col = '0;
                    n_row = r_row + ROW_BITS'(1);
                end else begin
                    n_col = COL_BITS'(col_inc);
                end
                if (emit) begin
                    n_ocnt = r_ocnt + TOT_BITS'(1);
                end
            end
        end

        n_s1.valid    = advance;
        n_s1.row_is1  = r_row == ROW_BITS'(1);
        n_s1.flushing = flushing;
        n_s1.emit     = emit;
        n_s1.emit_a   = emit_a;
        n_s1.sel_left = emit_a ? (i_weff == WEFF_BITS'(1)) : (r_col == COL_BITS'(1));
        n_s1.eoi      = last;
        n_s1.pix      = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_ocnt     <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_ocnt     <= n_ocnt;
            r_s1.valid <= n_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.row_is1  <= n_s1.row_is1;
        r_s1.flushing <= n_s1.flushing;
        r_s1.emit     <= n_s1.emit;
        r_s1.emit_a   <= n_s1.emit_a;
        r_s1.sel_left <= n_s1.sel_left;
        r_s1.eoi      <= n_s1.eoi;
        r_s1.pix      <= n_s1.pix;
        r_s1_col      <= r_col;
    end

    assign o_rd_en        = advance;
    assign o_rd_col       = r_col;
    assign o_result_taken = advance && emit;
    assign o_s1           = r_s1;
    assign o_s1_col       = r_s1_col;

endmodule

// File: design/cec_window.sv
// 3x3 window stage: builds the new column, writes line stores back, picks the neighborhood.
// Depends on cec_pkg.
module cec_window import cec_pkg::*; #(
    parameter int  MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_s1_ctl             i_s1,
    input  logic [COL_BITS-1:0] i_s1_col,
    input  t_rgb                i_upper,
    input  t_rgb                i_lower,
    output logic                o_wr_en,
    output logic [COL_BITS-1:0] o_wr_col,
    output t_rgb                o_wr_upper,
    output t_rgb                o_wr_lower,
    output t_nbr                o_nbr
);

    t_col r_win [3];   // 0 oldest column
    t_col new_col, left, mid, right;
    t_nbr r_nbr, n_nbr;

    always_comb begin
        new_col[0] = i_s1.row_is1 ? i_lower : i_upper;
        new_col[1] = i_lower;
        new_col[2] = i_s1.flushing ? i_lower : i_s1.pix;

        // old-window result uses columns (1|2, 2, 2); new-window result (old1|old2, old2, new)
        left  = i_s1.sel_left ? r_win[2] : r_win[1];
        mid   = r_win[2];
        right = i_s1.emit_a ? r_win[2] : new_col;

        n_nbr.valid = i_s1.valid && i_s1.emit;
        n_nbr.eoi   = i_s1.eoi;
        for (int r = 0; r < 3; r++) begin
            n_nbr.nbr[r][0] = left[r];
            n_nbr.nbr[r][1] = mid[r];
            n_nbr.nbr[r][2] = right[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0]    <= '0;
            r_win[1]    <= '0;
            r_win[2]    <= '0;
            r_nbr.valid <= 1'b0;
        end else begin
            if (i_s1.valid) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= new_col;
            end
            r_nbr.valid <= n_nbr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nbr.eoi <= n_nbr.eoi;
        r_nbr.nbr <= n_nbr.nbr;
    end

    assign o_wr_en    = i_s1.valid;
    assign o_wr_col   = i_s1_col;
    assign o_wr_upper = i_lower;
    assign o_wr_lower = new_col[2];
    assign o_nbr      = r_nbr;

endmodule

// File: design/cec_mac.sv
// Multiply-accumulate: 27 coefficient products registered, then per-channel sum and clamp.
// Depends on cec_pkg.
module cec_mac import cec_pkg::*; #(
    parameter int  COEF_BITS = COEF_BITS_DEF,
    localparam int PW        = COEF_BITS + 9,
    localparam int SW        = PW + 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [KERNEL_BITS-1:0] i_kernel,
    input  t_nbr                   i_nbr,
    output logic                   o_valid,
    output t_res                   o_res
);

    localparam logic signed [SW-1:0] PIX_MAX = 255;

    logic signed [COEF_BITS-1:0] coef [9];
    logic signed [8:0]           px   [3][9];
    logic signed [PW-1:0]        r_prod [3][9];
    logic                        r_valid;
    logic                        r_eoi;
    logic signed [SW-1:0]        sum  [3];
    logic [7:0]                  clip [3];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            coef[k] = i_kernel[k*COEF_BITS +: COEF_BITS];
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                px[ch][k] = {1'b0, i_nbr.nbr[k/3][k%3][16-8*ch +: 8]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[ch][k] <= PW'(coef[k]) * PW'(px[ch][k]);
            end
        end
        r_eoi <= i_nbr.eoi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_nbr.valid;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                sum[ch] = sum[ch] + SW'(r_prod[ch][k]);
            end
            if (sum[ch] < 0) begin
                clip[ch] = 8'd0;
            end else if (sum[ch] > PIX_MAX) begin
                clip[ch] = 8'hFF;
            end else begin
                clip[ch] = sum[ch][7:0];
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_res.red_out      = clip[0];
    assign o_res.green_out    = clip[1];
    assign o_res.blue_out     = clip[2];
    assign o_res.end_of_image = r_eoi;

endmodule

// File: design/cec_checker.sv
// Port-level checks for conv3x3_edge_clamp_unit, attached by bind.
// Depends on cec_pkg and the top level.
module cec_checker import cec_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_pix_valid,
    input logic                    i_pix_ready,
    input logic                    i_cfg_valid,
    input logic                    i_cfg_ready,
    input logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input t_res                    i_res_data
);

    // reset empties the output queue
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // pipeline depth: nothing can come out in the first cycles after reset
    a_min_latency: assert property (@(posedge i_clk)
        (!i_rst_n ##1 i_rst_n) |-> !i_res_valid ##1 !i_res_valid ##1 !i_res_valid)
        else $error("result appeared faster than the pipeline allows");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("stalled result changed or vanished");

    // geometry change blocks pixels for a cycle while the pixel count settles
    a_geom_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready
        && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT) |=> !i_pix_ready)
        else $error("pixel request accepted right after geometry write");

    // keep the pixel valid input referenced for waveform context
    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |-> !$isunknown(i_pix_ready))
        else $error("pixel ready unknown on accept");

endmodule

bind conv3x3_edge_clamp_unit cec_checker u_cec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
